[rtl/plist_pkg.sv]
// plist_pkg: shared types, codes and constants for the positional list engine.
// Used by every module under rtl/ through scoped names; depends on nothing.
package plist_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam word_t             NEG_ONE    = '1;
  localparam word_t             WORD_ZERO  = '0;
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
  localparam logic [POS_W-1:0]  POS_ONE    = POS_W'(1);
  localparam idx_t              LAST_IDX   = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_DELETE  = 2'd2,
    MODE_SWAP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    mode_e            mode;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] other_position;
    word_t            value;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    word_t            taken_value;
    logic [CNT_W-1:0] entry_count;
    word_t            largest_value;
    logic [POS_W-1:0] largest_position;
    logic             in_order;
  } out_word_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SWAP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    idx_t     pos_idx;
    idx_t     oth_idx;
    word_t    val_a;
    word_t    val_b;
  } cell_ctl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic live;
    idx_t idx;
  } scan_ctl_t;

endpackage

[rtl/plist_cell.sv]
// plist_cell: one list slot; shifts from a neighbor, rotates, or takes a
// broadcast value. Depends on plist_pkg.
module plist_cell (
  input  logic                clk,
  input  plist_pkg::cell_ctl_t ctl,
  input  plist_pkg::idx_t     my_idx,
  input  plist_pkg::word_t    left_val,
  input  plist_pkg::word_t    right_val,
  output plist_pkg::word_t    val
);

  plist_pkg::word_t val_r;
  plist_pkg::word_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      plist_pkg::CELL_ROTATE: val_nxt = right_val;
      plist_pkg::CELL_INSERT: begin
        if (my_idx > ctl.pos_idx) begin
          val_nxt = left_val;
        end else if (my_idx == ctl.pos_idx) begin
          val_nxt = ctl.val_a;
        end
      end
      plist_pkg::CELL_REMOVE: begin
        if (my_idx >= ctl.pos_idx) begin
          val_nxt = right_val;
        end
      end
      plist_pkg::CELL_SWAP: begin
        if (my_idx == ctl.pos_idx) begin
          val_nxt = ctl.val_a;
        end else if (my_idx == ctl.oth_idx) begin
          val_nxt = ctl.val_b;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

[rtl/plist_scan.sv]
// plist_scan: running max, its position and order check over the head cell
// as the ring rotates past it. Depends on plist_pkg.
module plist_scan (
  input  logic                         clk,
  input  plist_pkg::scan_ctl_t         ctl,
  input  plist_pkg::word_t             head,
  output plist_pkg::word_t             max_val,
  output logic [plist_pkg::POS_W-1:0]  max_pos,
  output logic                         sorted
);

  plist_pkg::word_t              max_r, max_nxt;
  plist_pkg::word_t              prev_r, prev_nxt;
  logic [plist_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                          sorted_r, sorted_nxt;
  logic [plist_pkg::POS_W-1:0]   here_pos;

  assign here_pos = {1'b0, ctl.idx} + plist_pkg::POS_ONE;

  always_comb begin
    max_nxt    = max_r;
    prev_nxt   = prev_r;
    pos_nxt    = pos_r;
    sorted_nxt = sorted_r;
    if (ctl.clear) begin
      max_nxt    = plist_pkg::NEG_ONE;
      pos_nxt    = '0;
      sorted_nxt = 1'b1;
    end else if (ctl.step && ctl.live) begin
      prev_nxt = head;
      if (ctl.idx == '0) begin
        max_nxt = head;
        pos_nxt = here_pos;
      end else begin
        if (head > max_r) begin
          max_nxt = head;
          pos_nxt = here_pos;
        end
        if (prev_r > head) begin
          sorted_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    max_r    <= max_nxt;
    prev_r   <= prev_nxt;
    pos_r    <= pos_nxt;
    sorted_r <= sorted_nxt;
  end

  assign max_val = max_r;
  assign max_pos = pos_r;
  assign sorted  = sorted_r;

endmodule

[rtl/positional_list_engine.sv]
// positional_list_engine: top level; ring of plist_cell slots, plist_scan at
// the head, request sequencer and output word register. Depends on plist_pkg.
//
//   channel | ports                      | word type
//   in      | in_valid, in_stall, in_word | plist_pkg::in_word_t
//   out     | out_valid, out_stall, out_word | plist_pkg::out_word_t
//
// Each request runs a full ring rotation to pick up the addressed entries, an
// apply step to shift/swap in place, and a second full rotation past the head
// cell to find the max and order.
// The ring rotations through the single head cell set the length of a request.
// Reset clears the count and control; entry storage is not cleared.
// A new word is taken while a finished result waits under out_stall.
module positional_list_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  plist_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output plist_pkg::out_word_t  out_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_APPLY,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                          state_r;
  logic [plist_pkg::CNT_W-1:0]     count_r;
  plist_pkg::idx_t                 k_r;
  plist_pkg::mode_e                req_mode_r;
  plist_pkg::idx_t                 req_pidx_r;
  plist_pkg::idx_t                 req_qidx_r;
  plist_pkg::word_t                req_value_r;
  plist_pkg::status_e              req_status_r;
  plist_pkg::word_t                t0_r;
  plist_pkg::word_t                t1_r;
  logic                            out_valid_r;
  plist_pkg::out_word_t            out_word_r;

  plist_pkg::status_e              in_status;
  logic [plist_pkg::POS_W-1:0]     pos_m1;
  logic [plist_pkg::POS_W-1:0]     oth_m1;
  logic [plist_pkg::CNT_W:0]       ins_limit;
  logic                            pos_bad;
  logic                            oth_bad;
  logic                            ins_bad;

  plist_pkg::cell_ctl_t            cell_ctl;
  plist_pkg::scan_ctl_t            scan_ctl;
  plist_pkg::word_t                cell_val [plist_pkg::DEPTH];
  plist_pkg::word_t                scan_max;
  logic [plist_pkg::POS_W-1:0]     scan_pos;
  logic                            scan_sorted;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign pos_m1    = in_word.position - plist_pkg::POS_ONE;
  assign oth_m1    = in_word.other_position - plist_pkg::POS_ONE;
  assign ins_limit = {1'b0, count_r} + {1'b0, plist_pkg::CNT_ONE};
  assign pos_bad   = (in_word.position == '0) || (in_word.position > count_r);
  assign oth_bad   = (in_word.other_position == '0) || (in_word.other_position > count_r);
  assign ins_bad   = (in_word.position == '0) || ({1'b0, in_word.position} > ins_limit);

  always_comb begin
    in_status = plist_pkg::STAT_DONE;
    case (in_word.mode)
      plist_pkg::MODE_INSERT: begin
        if (ins_bad) begin
          in_status = plist_pkg::STAT_RANGE;
        end else if (count_r == plist_pkg::FULL_COUNT) begin
          in_status = plist_pkg::STAT_FULL;
        end
      end
      plist_pkg::MODE_EXTRACT, plist_pkg::MODE_DELETE: begin
        if (pos_bad) in_status = plist_pkg::STAT_RANGE;
      end
      plist_pkg::MODE_SWAP: begin
        if (pos_bad || oth_bad) in_status = plist_pkg::STAT_RANGE;
      end
      default: in_status = plist_pkg::STAT_DONE;
    endcase
  end

  always_comb begin
    cell_ctl.op      = plist_pkg::CELL_HOLD;
    cell_ctl.pos_idx = req_pidx_r;
    cell_ctl.oth_idx = req_qidx_r;
    cell_ctl.val_a   = req_value_r;
    cell_ctl.val_b   = t0_r;
    if (state_r inside {S_GATHER, S_SCAN}) begin
      cell_ctl.op = plist_pkg::CELL_ROTATE;
    end else if (state_r == S_APPLY && req_status_r == plist_pkg::STAT_DONE) begin
      case (req_mode_r)
        plist_pkg::MODE_INSERT:  cell_ctl.op = plist_pkg::CELL_INSERT;
        plist_pkg::MODE_EXTRACT,
        plist_pkg::MODE_DELETE:  cell_ctl.op = plist_pkg::CELL_REMOVE;
        plist_pkg::MODE_SWAP: begin
          cell_ctl.op    = plist_pkg::CELL_SWAP;
          cell_ctl.val_a = t1_r;
        end
        default: cell_ctl.op = plist_pkg::CELL_HOLD;
      endcase
    end
  end

  assign scan_ctl.clear = (state_r == S_APPLY);
  assign scan_ctl.step  = (state_r == S_SCAN);
  assign scan_ctl.live  = ({1'b0, k_r} < count_r);
  assign scan_ctl.idx   = k_r;

  for (genvar g = 0; g < plist_pkg::DEPTH; g++) begin : g_cell
    plist_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .my_idx    (plist_pkg::IDX_W'(g)),
      .left_val  (cell_val[(g + plist_pkg::DEPTH - 1) % plist_pkg::DEPTH]),
      .right_val (cell_val[(g + 1) % plist_pkg::DEPTH]),
      .val       (cell_val[g])
    );
  end

  plist_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .head    (cell_val[0]),
    .max_val (scan_max),
    .max_pos (scan_pos),
    .sorted  (scan_sorted)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_mode_r   <= in_word.mode;
            req_pidx_r   <= pos_m1[plist_pkg::IDX_W-1:0];
            req_qidx_r   <= oth_m1[plist_pkg::IDX_W-1:0];
            req_value_r  <= in_word.value;
            req_status_r <= in_status;
            k_r          <= '0;
            state_r      <= S_GATHER;
          end
        end
        S_GATHER: begin
          if (k_r == req_pidx_r) t0_r <= cell_val[0];
          if (k_r == req_qidx_r) t1_r <= cell_val[0];
          k_r <= k_r + 1'b1;
          if (k_r == plist_pkg::LAST_IDX) state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (req_status_r == plist_pkg::STAT_DONE) begin
            if (req_mode_r == plist_pkg::MODE_INSERT) begin
              count_r <= count_r + plist_pkg::CNT_ONE;
            end else if (req_mode_r == plist_pkg::MODE_EXTRACT ||
                         req_mode_r == plist_pkg::MODE_DELETE) begin
              count_r <= count_r - plist_pkg::CNT_ONE;
            end
          end
          k_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          k_r <= k_r + 1'b1;
          if (k_r == plist_pkg::LAST_IDX) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_word_r.status       <= req_status_r;
            if (req_mode_r == plist_pkg::MODE_EXTRACT) begin
              out_word_r.taken_value <= (req_status_r == plist_pkg::STAT_DONE) ?
                                        t0_r : plist_pkg::NEG_ONE;
            end else begin
              out_word_r.taken_value <= plist_pkg::WORD_ZERO;
            end
            out_word_r.entry_count      <= count_r;
            out_word_r.largest_value    <= scan_max;
            out_word_r.largest_position <= scan_pos;
            out_word_r.in_order         <= scan_sorted;
            state_r                     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/plist_checker.sv]
// plist_checker: port-level assertions for positional_list_engine, bound to
// the top level below. Depends on plist_pkg.
module plist_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input plist_pkg::out_word_t out_word
);

  // one request in flight: taking a word closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input word taken while a request is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.entry_count <= plist_pkg::FULL_COUNT))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == plist_pkg::STAT_FULL) |->
      (out_word.entry_count == plist_pkg::FULL_COUNT))
    else $error("full status with list not full");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.entry_count == '0) |->
      (out_word.largest_position == '0 && out_word.largest_value == plist_pkg::NEG_ONE &&
       out_word.in_order))
    else $error("empty list reported with a maximum");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word changed");

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);
